>>> hdl/rtim_pkg.sv
// Package for the reload timer: action codes, register addresses and the
// fixed-point constants for the tick arithmetic.
// No dependencies.
package rtim_pkg;

    // Width of the elapsed field as used by the timer (low bits of the input field)
    localparam int ELAPSED_BITS  = 16;
    localparam int ELAPSED_FIELD = 16;
    localparam int ELAPSED_W     = (ELAPSED_BITS < ELAPSED_FIELD) ? ELAPSED_BITS
                                                                  : ELAPSED_FIELD;

    // rate * elapsed / 1000 = (elapsed << (9 + k)) / 125, with rate = 4096 << k
    localparam int SHIFT_W   = 4;
    localparam int MAX_SHIFT = 15;
    localparam int PROD_W    = ELAPSED_W + MAX_SHIFT;
    // advance of 256 or more steps once the scaled product reaches 256 * 125
    localparam int LOW_W     = 15;
    localparam logic [LOW_W-1:0] OVF_LIMIT = LOW_W'(32000);

    // floor(p / 125) for p < 32000 as (p * RECIP) >> RECIP_SHIFT
    localparam int RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(33555);
    localparam int RECIP_SHIFT = 22;
    localparam int QPROD_W     = LOW_W + RECIP_W;

    localparam int COUNT_W = 8;

    localparam logic [15:0] ADDR_COUNT   = 16'hFF05;
    localparam logic [15:0] ADDR_RELOAD  = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

    localparam int RATE_LSB   = 0;
    localparam int ENABLE_BIT = 2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [ELAPSED_FIELD-1:0] elapsed_ms;
        logic [7:0]               write_data;
        logic [15:0]              reg_address;
        action_t                  action;
    } in_item_t;

    localparam int IN_W   = $bits(in_item_t);
    localparam int IN_PAD = ((IN_W + 7) / 8) * 8;

    // Left shift for each rate select: 4096, 262144, 65536, 16384 Hz
    function automatic logic [SHIFT_W-1:0] rate_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] sh;
        case (sel)
            2'd0:    sh = SHIFT_W'(9);
            2'd1:    sh = SHIFT_W'(15);
            2'd2:    sh = SHIFT_W'(13);
            2'd3:    sh = SHIFT_W'(11);
            default: sh = SHIFT_W'(9);
        endcase
        return sh;
    endfunction

endpackage

>>> hdl/reload_timer_with_irq.sv
// Reload timer top level: three bus registers, tick arithmetic and the
// registered result stage.
// Depends on rtim_pkg.
//
// Usage:
//   Input channel (s_axis): one transaction is a tick carrying elapsed
//   milliseconds, a register write or a register read. Counter, reload and
//   control registers sit at 0xFF05, 0xFF06 and 0xFF07.
//   Result channel (m_axis): exactly one transaction per input transaction,
//   carrying read data (reads only) and the interrupt flag (ticks only).
//   The result is registered, valid in the cycle after the input transaction.
//   Throughput is one transaction per cycle unless the receiver stalls, set by
//   the single output register; register updates apply to the next transaction.
//   The first tick after reset only primes the timer. A tick with the enable
//   bit (control bit 2) clear leaves the counter unchanged.
//   Reset clears the three bus registers, the primed flag and the output valid.
//   While the receiver stalls, the pending result holds and s_axis_tready
//   stays low; a new transaction is taken in the same cycle the pending
//   result is taken.
module reload_timer_with_irq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], reg_address[17:2], write_data[25:18], elapsed_ms[41:26], zero pad
    input  logic [rtim_pkg::IN_PAD-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], timer_irq[8], zero pad
    output logic [15:0] m_axis_tdata
);
    import rtim_pkg::*;

    in_item_t item;

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [COUNT_W-1:0] reload_reg,  reload_next;
    logic [COUNT_W-1:0] control_reg, control_next;
    logic               primed_reg,  primed_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         rdata_reg,   rdata_next;
    logic               irq_reg,     irq_next;

    logic                 accept;
    logic [PROD_W-1:0]    scaled;
    logic                 big_advance;
    logic [QPROD_W-1:0]   qprod;
    logic [COUNT_W-1:0]   steps;
    logic [COUNT_W:0]     sum;
    logic                 overflow;

    assign item          = in_item_t'(s_axis_tdata[IN_W-1:0]);
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Scaled elapsed time, in units of 1/125 counter step
    assign scaled = PROD_W'(item.elapsed_ms[ELAPSED_W-1:0])
                    << rate_shift(control_reg[RATE_LSB +: 2]);
    assign big_advance = (scaled[PROD_W-1:LOW_W] != '0) || (scaled[LOW_W-1:0] >= OVF_LIMIT);
    assign qprod    = QPROD_W'(scaled[LOW_W-1:0]) * QPROD_W'(RECIP);
    assign steps    = qprod[RECIP_SHIFT +: COUNT_W];
    assign sum      = {1'b0, count_reg} + {1'b0, steps};
    assign overflow = big_advance || sum[COUNT_W];

    always_comb begin
        count_next   = count_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        primed_next  = primed_reg;
        m_valid_next = m_valid_reg;
        rdata_next   = rdata_reg;
        irq_next     = irq_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            rdata_next   = '0;
            irq_next     = 1'b0;
            case (item.action)
                ACT_TICK: begin
                    if (!primed_reg) begin
                        primed_next = 1'b1;
                    end else if (control_reg[ENABLE_BIT]) begin
                        if (overflow) begin
                            count_next = reload_reg;
                            irq_next   = 1'b1;
                        end else begin
                            count_next = sum[COUNT_W-1:0];
                        end
                    end
                end
                ACT_WRITE: begin
                    if (item.reg_address == ADDR_COUNT) begin
                        count_next = item.write_data;
                    end else if (item.reg_address == ADDR_RELOAD) begin
                        reload_next = item.write_data;
                    end else if (item.reg_address == ADDR_CONTROL) begin
                        control_next = item.write_data;
                    end
                end
                ACT_READ: begin
                    if (item.reg_address == ADDR_COUNT) begin
                        rdata_next = count_reg;
                    end else if (item.reg_address == ADDR_RELOAD) begin
                        rdata_next = reload_reg;
                    end else if (item.reg_address == ADDR_CONTROL) begin
                        rdata_next = control_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            reload_reg  <= '0;
            control_reg <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
        rdata_reg <= rdata_next;
        irq_reg   <= irq_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, irq_reg, rdata_reg};

    // An interrupt result never carries read data
    a_irq_no_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && irq_reg |-> rdata_reg == '0)
        else $error("interrupt result carries read data");

    // An overflowing tick leaves the counter at the reload value
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.action == ACT_TICK && primed_reg && control_reg[ENABLE_BIT]
        && overflow |=> count_reg == $past(reload_reg) && irq_reg)
        else $error("overflow did not reload the counter");

    // Once primed, the timer stays primed until reset
    a_primed_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    // Each accepted transaction yields a pending result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_axis_tvalid)
        else $error("accepted transaction lost its result");

endmodule

>>> verif/rtim_checker.sv
// Checker for the reload timer: watches both stream channels, predicts each
// result from its own timer model and compares field by field.
// Depends on rtim_pkg.
module rtim_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [rtim_pkg::IN_PAD-1:0] s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [15:0]                 m_axis_tdata,
    output int                          fail_count,
    output int                          pending,
    output int                          tick_count,
    output int                          irq_count,
    output int                          read_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rtim_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } timer_result_t;

    timer_result_t expected_q[$];
    timer_result_t head;
    in_item_t      bus_item;

    // timer model state
    logic [7:0] count_m;
    logic [7:0] reload_m;
    logic [7:0] control_m;
    logic       primed_m;

    int errs, ticks, irqs, reads;

    function automatic longint unsigned rate_hz(input logic [1:0] sel);
        case (sel)
            2'd0:    return 64'd4096;
            2'd1:    return 64'd262144;
            2'd2:    return 64'd65536;
            default: return 64'd16384;
        endcase
    endfunction

    // Apply one transaction to the model and return the result it causes
    function automatic timer_result_t advance_timer(input in_item_t it);
        timer_result_t     r;
        longint unsigned   span;
        longint unsigned   steps;
        longint unsigned   total;
        r = '0;
        case (it.action)
            ACT_TICK: begin
                if (!primed_m) begin
                    primed_m = 1'b1;
                end else if (control_m[ENABLE_BIT]) begin
                    span  = longint'(it.elapsed_ms) & ((64'd1 << ELAPSED_W) - 64'd1);
                    steps = rate_hz(control_m[RATE_LSB +: 2]) * span / 64'd1000;
                    total = 64'(count_m) + steps;
                    if (total > 64'd255) begin
                        count_m     = reload_m;
                        r.timer_irq = 1'b1;
                    end else begin
                        count_m = total[7:0];
                    end
                end
            end
            ACT_WRITE: begin
                case (it.reg_address)
                    ADDR_COUNT:   count_m   = it.write_data;
                    ADDR_RELOAD:  reload_m  = it.write_data;
                    ADDR_CONTROL: control_m = it.write_data;
                    default: ;
                endcase
            end
            ACT_READ: begin
                case (it.reg_address)
                    ADDR_COUNT:   r.read_data = count_m;
                    ADDR_RELOAD:  r.read_data = reload_m;
                    ADDR_CONTROL: r.read_data = control_m;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            count_m   = '0;
            reload_m  = '0;
            control_m = '0;
            primed_m  = 1'b0;
            errs  = 0;
            ticks = 0;
            irqs  = 0;
            reads = 0;
        end else begin
            // retire the oldest expectation before queuing the new one
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: tdata %04h", m_axis_tdata);
                    errs++;
                end else begin
                    head = expected_q.pop_front();
                    if (m_axis_tdata[7:0] !== head.read_data) begin
                        $error("read_data: expected %02h, got %02h",
                               head.read_data, m_axis_tdata[7:0]);
                        errs++;
                    end
                    if (m_axis_tdata[8] !== head.timer_irq) begin
                        $error("timer_irq: expected %0b, got %0b",
                               head.timer_irq, m_axis_tdata[8]);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bus_item = in_item_t'(s_axis_tdata[IN_W-1:0]);
                head     = advance_timer(bus_item);
                expected_q.push_back(head);
                if (bus_item.action == ACT_TICK) ticks++;
                if (bus_item.action == ACT_READ) reads++;
                if (head.timer_irq) irqs++;
            end
        end
        fail_count <= errs;
        pending    <= expected_q.size();
        tick_count <= ticks;
        irq_count  <= irqs;
        read_count <= reads;
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the reload timer: clock, reset, bus stimulus and
// receiver back-pressure; the verdict comes from rtim_checker.
// Depends on rtim_pkg, reload_timer_with_irq and rtim_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rtim_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 80;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_PAD-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;

    int fail_count, pending, tick_count, irq_count, read_count;
    int idle_pct;
    int stall_pct;
    int sent;
    logic hold_req;
    logic hold_done;

    reload_timer_with_irq i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rtim_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .tick_count    (tick_count),
        .irq_count     (irq_count),
        .read_count    (read_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic in_item_t bus_tick(input logic [15:0] elapsed);
        in_item_t it;
        it            = '0;
        it.action     = ACT_TICK;
        it.elapsed_ms = elapsed;
        return it;
    endfunction

    function automatic in_item_t bus_write(input logic [15:0] addr, input logic [7:0] data);
        in_item_t it;
        it             = '0;
        it.action      = ACT_WRITE;
        it.reg_address = addr;
        it.write_data  = data;
        return it;
    endfunction

    function automatic in_item_t bus_read(input logic [15:0] addr);
        in_item_t it;
        it             = '0;
        it.action      = ACT_READ;
        it.reg_address = addr;
        return it;
    endfunction

    // Mostly well-formed bus traffic: known addresses, short ticks, enabled timer
    function automatic in_item_t random_bus_item();
        in_item_t    it;
        int unsigned pick;
        pick          = $urandom_range(99);
        it.write_data = 8'($urandom_range(255));
        it.elapsed_ms = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(40));
        case ($urandom_range(2))
            0:       it.reg_address = ADDR_COUNT;
            1:       it.reg_address = ADDR_RELOAD;
            default: it.reg_address = ADDR_CONTROL;
        endcase
        if ($urandom_range(9) == 0)
            it.reg_address = 16'($urandom_range(65535));
        if (pick < 45)
            it.action = ACT_TICK;
        else if (pick < 70)
            it.action = ACT_WRITE;
        else if (pick < 95)
            it.action = ACT_READ;
        else
            it.action = ACT_NONE;
        // keep the timer enabled most of the time
        if (it.action == ACT_WRITE && it.reg_address == ADDR_CONTROL && $urandom_range(4) != 0)
            it.write_data[ENABLE_BIT] = 1'b1;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input in_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_PAD'(it);
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int       idle_tab[4];
        int       stall_tab[4];
        in_item_t odd_item;
        idle_tab  = '{0, 50, 0, 34};
        stall_tab = '{0, 0, 50, 34};
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        sent          = 0;
        hold_req      = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset values, priming, disabled ticks, each rate, overflow
        offer(bus_read(ADDR_COUNT));
        offer(bus_read(ADDR_RELOAD));
        offer(bus_read(ADDR_CONTROL));
        offer(bus_write(ADDR_CONTROL, 8'h07));
        offer(bus_tick(16'hFFFF));              // priming tick discards elapsed time
        offer(bus_read(ADDR_COUNT));
        offer(bus_write(ADDR_CONTROL, 8'hF8));  // upper bits only, timer disabled
        offer(bus_read(ADDR_CONTROL));
        offer(bus_tick(16'hFFFF));
        offer(bus_write(ADDR_RELOAD, 8'hFF));
        offer(bus_write(ADDR_COUNT, 8'h10));
        offer(bus_write(ADDR_CONTROL, 8'h04));
        offer(bus_tick(16'd10));
        offer(bus_tick(16'd0));
        offer(bus_write(ADDR_CONTROL, 8'h05));
        offer(bus_tick(16'd1));                 // overflow, reload from 0xFF
        offer(bus_tick(16'hFFFF));              // huge advance still reloads once
        offer(bus_write(ADDR_COUNT, 8'h00));
        offer(bus_write(ADDR_CONTROL, 8'h06));
        offer(bus_tick(16'd3));
        offer(bus_write(ADDR_CONTROL, 8'h07));
        offer(bus_tick(16'd15));
        offer(bus_write(16'h0000, 8'hAA));      // unknown address is ignored
        offer(bus_read(16'hFFFF));
        offer(bus_read(16'hFF04));
        odd_item = random_bus_item();
        odd_item.action = ACT_NONE;
        offer(odd_item);
        offer(bus_read(ADDR_COUNT));

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0)
                hold_req = 1'b1;
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
                offer(random_bus_item());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
        $display("Run covered %0d bus transactions across four idling patterns and one long",
                 sent);
        $display("result hold-off: %0d ticks, %0d interrupts, %0d reads checked.",
                 tick_count, irq_count, read_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #500us;
        $display("Timeout: %0d results still outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
